// File: design/wmi_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and rom tables for the windowed mdct / imdct block
// no dependencies

package wmi_pkg;

  localparam int FRAME_LEN = 2048;
  localparam int HALF_LEN  = FRAME_LEN / 2;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int CNT_W     = IDX_W + 1;
  localparam int PH_W      = $clog2(4 * FRAME_LEN);
  localparam int DATA_W    = 32;
  localparam int ROM_W     = 16;
  localparam int FRAC      = 15;
  localparam int CS_W      = ROM_W + 1;
  localparam int WC_W      = 2 * CS_W;
  localparam int COEF_W    = 18;
  localparam int MUL_W     = DATA_W + COEF_W;
  localparam int ACC_W     = 60;
  localparam int RND_W     = ACC_W - FRAC;
  localparam int SCL_W     = RND_W + CS_W;
  localparam int INV_SHIFT = IDX_W + 13;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic {
    OP_STORE   = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_t;

  typedef enum logic {
    MODE_FWD = 1'b0,
    MODE_INV = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_SCALE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store_we;
    logic start;
    logic issue;
    logic round;
    logic scale;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic req_in_range;
    logic last_issue;
    logic pipe_empty;
    logic out_free;
  } dp_status_t;

  typedef logic [ROM_W-1:0] rom_t [FRAME_LEN];

  // cos(pi/2 * i/N) in q15, taylor series in unsigned q30
  function automatic rom_t build_cos_rom();
    rom_t              tbl;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] sum;
    for (int i = 0; i < FRAME_LEN; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / 64'(FRAME_LEN);
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = $signed(term);
      for (int j = 1; j <= 9; j++) begin
        term = ((term * x2) >> 30) / 64'((2 * j - 1) * (2 * j));
        if ((j % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32767) begin
        sum = 64'sd32767;
      end
      tbl[i] = sum[ROM_W-1:0];
    end
    return tbl;
  endfunction

  // sin(pi (2i+1) / 2N) taken from the quarter-wave table
  function automatic rom_t build_win_rom(rom_t cos_tbl);
    rom_t tbl;
    int   d;
    for (int i = 0; i < FRAME_LEN; i++) begin
      d = FRAME_LEN - (2 * i + 1);
      if (d < 0) begin
        d = -d;
      end
      tbl[i] = (d < FRAME_LEN) ? cos_tbl[d] : '0;
    end
    return tbl;
  endfunction

  localparam rom_t COS_ROM = build_cos_rom();
  localparam rom_t WIN_ROM = build_win_rom(COS_ROM);

endpackage

// File: design/wmi_channels.sv
`timescale 1ns / 1ps
// valid / ready channel interfaces: request, result and mode write
// depends on wmi_pkg

interface wmi_req_if import wmi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IDX_W-1:0]         item_index;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, output opcode, output item_index, output data_value,
                  input ready);
  modport sink (input valid, input opcode, input item_index, input data_value,
                output ready);
endinterface

interface wmi_res_if import wmi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_index;
  logic signed [DATA_W-1:0] out_value;
  logic                     saturated;

  modport source (output valid, output out_index, output out_value, output saturated,
                  input ready);
  modport sink (input valid, input out_index, input out_value, input saturated,
                output ready);
endinterface

interface wmi_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, output mode, input ready);
  modport sink (input valid, input mode, output ready);
endinterface

// File: design/wmi_ctrl.sv
`timescale 1ns / 1ps
// sequencer for store, multiply-accumulate sweep, rounding and result hand-off
// depends on wmi_pkg

module wmi_ctrl import wmi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_opcode,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   is_compute;

  assign is_compute = (opcode_t'(in_opcode) == OP_COMPUTE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && is_compute) begin
          state_nxt = status.req_in_range ? ST_RUN : ST_EMIT;
        end
      end
      ST_RUN: begin
        if (status.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.store_we = in_valid && !is_compute;
        cmd.start    = in_valid && is_compute;
      end
      ST_RUN:   cmd.issue = 1'b1;
      ST_DRAIN: cmd = '0;
      ST_ROUND: cmd.round = 1'b1;
      ST_SCALE: cmd.scale = 1'b1;
      ST_EMIT:  cmd.emit = status.out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && status.last_issue) |=> (state_r == ST_DRAIN))
    else $error("sweep did not end after last issue");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && status.out_free) |=> (state_r == ST_IDLE))
    else $error("result hand-off did not return to idle");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (!cmd.start && !cmd.store_we))
    else $error("request taken while busy");

endmodule

// File: design/wmi_datapath.sv
`timescale 1ns / 1ps
// frame store, cosine and window roms, phase stepping, mac pipeline,
// rounding, saturation and result register; depends on wmi_pkg

module wmi_datapath import wmi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic                     cfg_mode,
  input  logic [IDX_W-1:0]         in_item_index,
  input  logic signed [DATA_W-1:0] in_data_value,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_saturated
);

  localparam logic signed [RND_W-1:0] SAT_HI =
    {{(RND_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [RND_W-1:0] SAT_LO =
    {{(RND_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam logic [PH_W-1:0] PH_OFS = PH_W'(HALF_LEN + 1);

  logic signed [DATA_W-1:0] frame_store_r [FRAME_LEN];

  mode_t                    mode_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     oor_r;
  logic [CNT_W-1:0]         j_r;
  logic [PH_W-1:0]          ph_r;
  logic [PH_W-1:0]          step_r;
  logic                     va_r, vb_r, vc_r;
  logic                     neg_a_r, zero_a_r;
  logic signed [DATA_W-1:0] x_q_r;
  logic [ROM_W-1:0]         cos_q_r;
  logic [ROM_W-1:0]         win_q_r;
  logic signed [DATA_W-1:0] x_b_r;
  logic signed [COEF_W-1:0] coef_r;
  logic signed [MUL_W-1:0]  mul_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RND_W-1:0]  rnd_r;
  logic signed [RND_W-1:0]  fin_r;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_index_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_sat_r;

  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         rem;
  logic [1:0]               quad;
  logic [IDX_W-1:0]         cos_addr;
  logic [IDX_W-1:0]         win_addr;
  logic [PH_W-1:0]          odd_idx;
  logic [PH_W-1:0]          ph_init;
  logic [PH_W-1:0]          step_init;
  logic [CNT_W-1:0]         last_j;
  logic signed [CS_W-1:0]   c_s;
  logic signed [WC_W-1:0]   wc_sum;
  logic signed [COEF_W-1:0] coef_nxt;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [SCL_W-1:0]  scl_sum;
  logic signed [RND_W-1:0]  fin_nxt;

  // phase walk: forward steps over n, inverse over k, both mod 4N
  assign odd_idx = PH_W'({in_item_index, 1'b1});
  always_comb begin
    if (mode_r == MODE_INV) begin
      ph_init   = odd_idx + PH_W'(HALF_LEN);
      step_init = {ph_init[PH_W-2:0], 1'b0};
    end else begin
      ph_init   = PH_W'(PH_OFS * odd_idx);
      step_init = {odd_idx[PH_W-2:0], 1'b0};
    end
  end

  assign rd_addr  = j_r[IDX_W-1:0];
  assign rem      = ph_r[IDX_W-1:0];
  assign quad     = ph_r[PH_W-1:PH_W-2];
  assign cos_addr = quad[0] ? (IDX_W'(0) - rem) : rem;
  assign win_addr = (mode_r == MODE_INV) ? idx_r : rd_addr;
  assign last_j   = (mode_r == MODE_INV) ? CNT_W'(HALF_LEN - 1) : CNT_W'(FRAME_LEN - 1);

  assign status.req_in_range = (mode_r == MODE_INV) ||
                               ({1'b0, in_item_index} < CNT_W'(HALF_LEN));
  assign status.last_issue   = cmd.issue && (j_r == last_j);
  assign status.pipe_empty   = !(va_r || vb_r || vc_r);
  assign status.out_free     = !out_valid_r || out_ready;

  // stage b: signed cosine, window folded in for the forward transform
  always_comb begin
    if (zero_a_r) begin
      c_s = '0;
    end else if (neg_a_r) begin
      c_s = -$signed({1'b0, cos_q_r});
    end else begin
      c_s = $signed({1'b0, cos_q_r});
    end
    wc_sum = (WC_W'($signed({1'b0, win_q_r})) * WC_W'(c_s)) +
             (WC_W'(1) <<< (FRAC - 1));
    if (mode_r == MODE_INV) begin
      coef_nxt = COEF_W'(c_s);
    end else begin
      coef_nxt = wc_sum[FRAC+COEF_W-1:FRAC];
    end
  end

  // result rounding and inverse scaling by w[n] * 4/N
  assign acc_rnd = acc_r + (ACC_W'(1) <<< (FRAC - 1));
  assign scl_sum = (SCL_W'(rnd_r) * SCL_W'($signed({1'b0, win_q_r}))) +
                   (SCL_W'(1) <<< (INV_SHIFT - 1));
  always_comb begin
    if (mode_r == MODE_INV) begin
      fin_nxt = RND_W'($signed(scl_sum[SCL_W-1:INV_SHIFT]));
    end else begin
      fin_nxt = rnd_r;
    end
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    if (cmd.store_we) begin
      frame_store_r[in_item_index] <= in_data_value;
    end
    x_q_r   <= frame_store_r[rd_addr];
    cos_q_r <= COS_ROM[cos_addr];
    win_q_r <= WIN_ROM[win_addr];
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    neg_a_r  <= quad[1] ^ quad[0];
    zero_a_r <= quad[0] && (rem == '0);
    x_b_r    <= x_q_r;
    coef_r   <= coef_nxt;
    mul_r    <= MUL_W'(x_b_r) * MUL_W'(coef_r);
    if (cmd.start) begin
      idx_r  <= in_item_index;
      oor_r  <= !status.req_in_range;
      ph_r   <= ph_init;
      step_r <= step_init;
      acc_r  <= '0;
    end else begin
      if (cmd.issue) begin
        ph_r <= ph_r + step_r;
      end
      if (vc_r) begin
        acc_r <= acc_r + ACC_W'(mul_r);
      end
    end
    if (cmd.round) begin
      rnd_r <= acc_rnd[ACC_W-1:FRAC];
    end
    if (cmd.scale) begin
      fin_r <= fin_nxt;
    end
    if (cmd.emit) begin
      out_index_r <= idx_r;
      if (oor_r) begin
        out_value_r <= '0;
        out_sat_r   <= 1'b0;
      end else if (fin_r > SAT_HI) begin
        out_value_r <= SAT_HI[DATA_W-1:0];
        out_sat_r   <= 1'b1;
      end else if (fin_r < SAT_LO) begin
        out_value_r <= SAT_LO[DATA_W-1:0];
        out_sat_r   <= 1'b1;
      end else begin
        out_value_r <= fin_r[DATA_W-1:0];
        out_sat_r   <= 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FWD;
      j_r         <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r <= mode_t'(cfg_mode);
      end
      if (cmd.start) begin
        j_r <= '0;
      end else if (cmd.issue) begin
        j_r <= j_r + 1'b1;
      end
      va_r <= cmd.issue;
      vb_r <= va_r;
      vc_r <= vb_r;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(va_r || vb_r || vc_r))
    else $error("result taken before accumulation finished");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_value_r == SAT_HI[DATA_W-1:0] ||
                                    out_value_r == SAT_LO[DATA_W-1:0]))
    else $error("saturated flag on a value that is not a rail");

  a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_we |-> (!cmd.issue && !va_r && !vc_r))
    else $error("store write during accumulation");

endmodule

// File: design/windowed_mdct_imdct.sv
`timescale 1ns / 1ps
// Windowed MDCT / IMDCT over one frame of N = 2048 held in an on-chip frame
// store, sine window, Q15 tables. A store request writes the frame store as
// it is accepted. A compute request runs one multiply-accumulate per cycle
// over the single read port of the frame store: N terms in forward mode, N/2
// in inverse mode, then pipeline fill, rounding, scaling and hand-off. One
// request is worked on at a time; a finished result waits in the output
// register while the next request is taken. Mode must be written only while
// the block is idle; the block itself does not enforce this. The frame store
// has no reset; every entry a compute reads must have been stored.
// Depends on wmi_pkg, wmi_channels, wmi_ctrl and wmi_datapath.

module windowed_mdct_imdct import wmi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wmi_req_if.sink   in_req,
  wmi_res_if.source out_res,
  wmi_cfg_if.sink   cfg_wr
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_wr.ready = 1'b1;

  wmi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_opcode (in_req.opcode),
    .in_ready  (in_req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  wmi_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_wr.valid),
    .cfg_mode      (cfg_wr.mode),
    .in_item_index (in_req.item_index),
    .in_data_value (in_req.data_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_res.valid),
    .out_ready     (out_res.ready),
    .out_index     (out_res.out_index),
    .out_value     (out_res.out_value),
    .out_saturated (out_res.saturated)
  );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for windowed_mdct_imdct: fills the frame store, drives
// store and compute requests in both modes and checks every result
// depends on wmi_pkg, wmi_channels and the rtl top level

module tb_top;
  import wmi_pkg::*;

  localparam logic [63:0]       QTR_TURN_Q30 = 64'd1686629713;
  localparam longint            SAT_HI       = 64'sd2147483647;
  localparam longint            SAT_LO       = -64'sd2147483648;
  localparam logic signed [31:0] SAMPLE_MAX  = 32'sh7fffffff;
  localparam logic signed [31:0] SAMPLE_MIN  = 32'sh80000000;

  typedef struct packed {
    opcode_t                  op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] data;
  } frame_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } xform_res_t;

  logic clk;
  logic rst_n;

  wmi_req_if req_if ();
  wmi_res_if res_if ();
  wmi_cfg_if cfg_if ();

  windowed_mdct_imdct u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_res(res_if),
    .cfg_wr (cfg_if)
  );

  logic [ROM_W-1:0]         cos_tbl   [FRAME_LEN];
  logic [ROM_W-1:0]         win_tbl   [FRAME_LEN];
  logic signed [DATA_W-1:0] frame_mem [FRAME_LEN];
  mode_t                    cur_mode;

  frame_req_t frame_req_q [$];
  xform_res_t xform_due_q [$];

  int   send_idle_pct;
  int   recv_stall_pct;
  int   err_cnt;
  int   req_cnt;
  int   result_cnt;
  int   clip_cnt;
  logic req_taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  // cosine of the mdct angle, in units of pi/(2N), from the quarter-wave table
  function automatic longint mdct_cos(int n, int k);
    int     p;
    int     r;
    longint c;
    p = ((2 * n + 1 + HALF_LEN) * (2 * k + 1)) % (4 * FRAME_LEN);
    r = p % FRAME_LEN;
    if ((p / FRAME_LEN) % 2 == 1) begin
      c = (r == 0) ? 0 : cos_tbl[FRAME_LEN - r];
    end else begin
      c = cos_tbl[r];
    end
    return (p / FRAME_LEN == 1 || p / FRAME_LEN == 2) ? -c : c;
  endfunction

  function automatic bit run_frame_req(input frame_req_t rq, output xform_res_t res);
    longint acc;
    longint wc;
    longint xv;
    longint wv;
    longint u;
    longint val;
    int     pos;
    pos = rq.idx;
    res = '0;
    if (rq.op == OP_STORE) begin
      frame_mem[pos] = rq.data;
      return 1'b0;
    end
    acc = 0;
    val = 0;
    if (cur_mode == MODE_FWD) begin
      if (pos < HALF_LEN) begin
        for (int n = 0; n < FRAME_LEN; n++) begin
          wv  = win_tbl[n];
          wc  = (wv * mdct_cos(n, pos) + 16384) >>> 15;
          xv  = frame_mem[n];
          acc += xv * wc;
        end
        val = (acc + 16384) >>> 15;
      end
    end else begin
      for (int k = 0; k < HALF_LEN; k++) begin
        xv  = frame_mem[k];
        acc += xv * mdct_cos(pos, k);
      end
      u   = (acc + 16384) >>> 15;
      wv  = win_tbl[pos];
      val = (4 * u * wv + longint'(FRAME_LEN) * 16384) >>> (IDX_W + 15);
    end
    res.idx = rq.idx;
    if (val > SAT_HI) begin
      val     = SAT_HI;
      res.sat = 1'b1;
    end else if (val < SAT_LO) begin
      val     = SAT_LO;
      res.sat = 1'b1;
    end
    res.value = val[DATA_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_sample(bit wide);
    int v;
    if (!wide) begin
      v = $urandom_range(65535);
      return v - 32768;
    end
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(opcode_t op, int idx, logic signed [DATA_W-1:0] data);
    frame_req_t rq;
    rq.op   = op;
    rq.idx  = IDX_W'(idx);
    rq.data = data;
    frame_req_q = {frame_req_q, rq};
  endtask

  task automatic wait_drained();
    while (frame_req_q.size() != 0 || xform_due_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_mode(mode_t m);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.mode  <= m;
    do @(posedge clk); while (!cfg_if.ready);
    cur_mode = m;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic fill_frame(bit wide);
    for (int i = 0; i < FRAME_LEN; i++) queue_req(OP_STORE, i, rand_sample(wide));
  endtask

  // coefficients matched in sign to the basis of sample N/2, which drives it to clip
  task automatic fill_aligned(bit negate);
    for (int k = 0; k < HALF_LEN; k++) begin
      queue_req(OP_STORE, k,
                ((mdct_cos(HALF_LEN, k) >= 0) != negate) ? SAMPLE_MAX : SAMPLE_MIN);
    end
  endtask

  task automatic random_burst(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 35) begin
        queue_req(OP_COMPUTE, $urandom_range(FRAME_LEN - 1), $urandom);
      end else begin
        queue_req(OP_STORE, $urandom_range(FRAME_LEN - 1),
                  rand_sample($urandom_range(4) == 0));
      end
    end
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // request side: predict on acceptance, offer the next one at the falling edge
  always @(posedge clk) begin : req_accept
    frame_req_t rq;
    xform_res_t res;
    req_taken <= rst_n && req_if.valid && req_if.ready;
    if (rst_n && req_if.valid && req_if.ready) begin
      rq = frame_req_q.pop_front();
      if (run_frame_req(rq, res)) xform_due_q = {xform_due_q, res};
      req_cnt++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (frame_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid      <= 1'b1;
        req_if.opcode     <= frame_req_q[0].op;
        req_if.item_index <= frame_req_q[0].idx;
        req_if.data_value <= frame_req_q[0].data;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    xform_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (xform_due_q.size() == 0) begin
        $error("result for index %0d arrived with none expected", res_if.out_index);
        err_cnt++;
      end else begin
        want = xform_due_q.pop_front();
        result_cnt++;
        if (want.sat) clip_cnt++;
        if (res_if.out_index !== want.idx) begin
          $error("out_index: expected %0d, got %0d", want.idx, res_if.out_index);
          err_cnt++;
        end
        if (res_if.out_value !== want.value) begin
          $error("out_value at index %0d: expected %0d, got %0d",
                 want.idx, want.value, res_if.out_value);
          err_cnt++;
        end
        if (res_if.saturated !== want.sat) begin
          $error("saturated at index %0d: expected %0b, got %0b",
                 want.idx, want.sat, res_if.saturated);
          err_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    int          d;
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.opcode     = OP_STORE;
    req_if.item_index = '0;
    req_if.data_value = '0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.mode       = MODE_FWD;
    cur_mode          = MODE_FWD;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    err_cnt           = 0;
    req_cnt           = 0;
    result_cnt        = 0;
    clip_cnt          = 0;
    req_taken         = 1'b0;

    // quarter-wave cosine by taylor series in unsigned q30, then the sine window
    for (int i = 0; i < FRAME_LEN; i++) begin
      x    = (QTR_TURN_Q30 * i) / FRAME_LEN;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      acc  = 64'sd1 << 30;
      for (int j = 1; j <= 9; j++) begin
        term = ((term * x2) >> 30) / ((2 * j - 1) * (2 * j));
        if (j % 2 == 1) begin
          acc -= $signed(term);
        end else begin
          acc += $signed(term);
        end
      end
      if (acc < 0) acc = 0;
      acc = (acc + 16384) >>> 15;
      if (acc > 32767) acc = 32767;
      cos_tbl[i] = acc[ROM_W-1:0];
    end
    for (int i = 0; i < FRAME_LEN; i++) begin
      d = FRAME_LEN - (2 * i + 1);
      if (d < 0) d = -d;
      win_tbl[i] = cos_tbl[d];
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // forward: full-scale frame clips, edges of k, out-of-range k
    write_mode(MODE_FWD);
    fill_frame(1'b1);
    queue_req(OP_COMPUTE, 0, '0);
    queue_req(OP_COMPUTE, HALF_LEN - 1, '1);
    queue_req(OP_COMPUTE, HALF_LEN, SAMPLE_MAX);
    queue_req(OP_COMPUTE, FRAME_LEN - 1, SAMPLE_MIN);
    queue_req(OP_STORE, 0, SAMPLE_MIN);
    queue_req(OP_STORE, FRAME_LEN - 1, SAMPLE_MAX);
    queue_req(OP_COMPUTE, 0, '0);
    queue_req(OP_STORE, 0, '0);
    queue_req(OP_STORE, FRAME_LEN - 1, '1);
    queue_req(OP_COMPUTE, 511, '0);
    wait_drained();
    fill_frame(1'b0);
    queue_req(OP_COMPUTE, 0, '0);
    queue_req(OP_COMPUTE, HALF_LEN - 1, '0);
    queue_req(OP_COMPUTE, 700, '0);
    wait_drained();
    random_burst(72, 0, 0);

    // inverse: aligned frame clips high then low, entries from N/2 up are unused
    write_mode(MODE_INV);
    fill_aligned(1'b0);
    queue_req(OP_COMPUTE, HALF_LEN, '0);
    queue_req(OP_COMPUTE, 0, '0);
    queue_req(OP_COMPUTE, FRAME_LEN - 1, '1);
    queue_req(OP_COMPUTE, HALF_LEN - 1, '0);
    queue_req(OP_STORE, HALF_LEN, SAMPLE_MAX);
    queue_req(OP_STORE, FRAME_LEN - 1, SAMPLE_MIN);
    queue_req(OP_COMPUTE, HALF_LEN, '0);
    wait_drained();
    fill_aligned(1'b1);
    queue_req(OP_COMPUTE, HALF_LEN, '0);
    queue_req(OP_COMPUTE, 512, '0);
    wait_drained();
    random_burst(72, 73, 0);

    write_mode(MODE_FWD);
    fill_frame(1'b0);
    wait_drained();
    random_burst(72, 0, 73);

    write_mode(MODE_INV);
    random_burst(74, 22, 22);

    for (int t = 0; t < 8 * FRAME_LEN && xform_due_q.size() != 0; t++) @(negedge clk);
    repeat (FRAME_LEN + 64) @(negedge clk);
    if (xform_due_q.size() != 0) begin
      $error("%0d results never arrived", xform_due_q.size());
      err_cnt++;
    end

    $display("%0d requests sent, %0d transform results checked, %0d of them clipped",
             req_cnt, result_cnt, clip_cnt);
    $display("covered forward and inverse modes under sender gaps and receiver stalls");
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/wmi_pkg.sv
design/wmi_channels.sv
design/wmi_ctrl.sv
design/wmi_datapath.sv
design/windowed_mdct_imdct.sv
dv/tb_top.sv
